@@ rtl/core/assert_macros.svh @@
// Assertion macros for the port checker module of the block.
// The macros expect a signal named clk, and CHK_ASSERT also arst_n, in the scope where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define CHK_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, during reset as well.
`define CHK_ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/jkse_pkg.sv @@
// Shared types and constants of the JSON key string extractor.
// No dependencies; jkse_cfg, jkse_core and the top level refer to it by scoped names, the testbench imports it.
package jkse_pkg;

	// Sizing defaults for the top level parameters
	localparam int MAX_KEY_CHARS_DEF = 24;
	localparam int MAX_OUT_SIZE_DEF  = 4096;

	// Key storage: three 64-bit registers of eight bytes each
	localparam int KEY_BYTES    = 24;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 64;
	localparam int KEY_LEN_W    = 5;
	localparam int OUT_SIZE_W   = 13;
	localparam int RST_KEY_LEN  = 1;
	localparam int RST_OUT_SIZE = 64;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_MID  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_KEY_LEN  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_SIZE = 3'd4;

	// Characters the parser reacts to
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	// Bytes dropped after a \u escape
	localparam logic [2:0] USKIP_N = 3'd4;

	// Parser phases
	typedef enum logic [6:0] {
		PH_MATCH = 7'b0000001,
		PH_COLON = 7'b0000010,
		PH_SPACE = 7'b0000100,
		PH_VALUE = 7'b0001000,
		PH_ESC   = 7'b0010000,
		PH_USKIP = 7'b0100000,
		PH_IDLE  = 7'b1000000
	} phase_t;

	// Key bytes plus what the parser needs to know about a colon inside the key
	typedef struct packed {
		logic [KEY_BYTES-1:0][7:0] chars;
		logic                      has_colon;
		logic                      tail_ok;
	} key_info_t;

endpackage

@@ rtl/core/jkse_cfg.sv @@
// Configuration registers of the extractor and the key and limit values derived from them.
// Depends on jkse_pkg.
module jkse_cfg #(
	parameter int MAX_KEY_CHARS = jkse_pkg::MAX_KEY_CHARS_DEF,
	parameter int MAX_OUT_SIZE  = jkse_pkg::MAX_OUT_SIZE_DEF,
	parameter int EFF_MAX       = (MAX_KEY_CHARS < 31) ? MAX_KEY_CHARS : 31,
	parameter int LEN_W         = $clog2(EFF_MAX + 1),
	parameter int LIM_W         = $clog2(MAX_OUT_SIZE)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [jkse_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [jkse_pkg::CFG_DATA_W-1:0]     cfg_data,
	output jkse_pkg::key_info_t                 key,
	output logic [LEN_W-1:0]                    eff_len,
	output logic [LIM_W-1:0]                    limit
);

	localparam int RST_OS    = (jkse_pkg::RST_OUT_SIZE > MAX_OUT_SIZE) ?
	                           MAX_OUT_SIZE : jkse_pkg::RST_OUT_SIZE;
	localparam int RST_LIMIT = RST_OS - 1;

	logic [jkse_pkg::CFG_DATA_W-1:0] key_low_q, key_mid_q, key_high_q;
	logic [jkse_pkg::KEY_LEN_W-1:0]  key_len_q;
	logic [jkse_pkg::OUT_SIZE_W-1:0] out_size_q;
	logic                            has_colon_q, tail_ok_q;
	logic                            has_colon_d, tail_ok_d;
	logic [LIM_W-1:0]                limit_q;
	logic [16:0]                     os_ext;
	logic [16:0]                     os_clamp;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q  <= '0;
			key_mid_q  <= '0;
			key_high_q <= '0;
			key_len_q  <= jkse_pkg::KEY_LEN_W'(jkse_pkg::RST_KEY_LEN);
			out_size_q <= jkse_pkg::OUT_SIZE_W'(jkse_pkg::RST_OUT_SIZE);
		end else if (cfg_we) begin
			case (cfg_index)
				jkse_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_data;
				jkse_pkg::CFG_KEY_MID:  key_mid_q  <= cfg_data;
				jkse_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data;
				jkse_pkg::CFG_KEY_LEN:  key_len_q  <= cfg_data[jkse_pkg::KEY_LEN_W-1:0];
				jkse_pkg::CFG_OUT_SIZE: out_size_q <= cfg_data[jkse_pkg::OUT_SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// Key length saturates at the largest supported key
	assign eff_len = (key_len_q > jkse_pkg::KEY_LEN_W'(EFF_MAX)) ?
	                 LEN_W'(EFF_MAX) : LEN_W'(key_len_q);

	assign key.chars     = {key_high_q, key_mid_q, key_low_q};
	assign key.has_colon = has_colon_q;
	assign key.tail_ok   = tail_ok_q;

	// Colon in key: value may start right after the key only if the colon
	// is followed by nothing but spaces and tabs inside the key
	always_comb begin
		logic seen;
		seen        = 1'b0;
		has_colon_d = 1'b0;
		tail_ok_d   = 1'b1;
		for (int j = 0; j < jkse_pkg::KEY_BYTES; j++) begin
			if (int'(eff_len) > j) begin
				if (seen && !(key.chars[j] inside {jkse_pkg::CH_SPACE, jkse_pkg::CH_TAB}))
					tail_ok_d = 1'b0;
				if (key.chars[j] == jkse_pkg::CH_COLON) begin
					seen        = 1'b1;
					has_colon_d = 1'b1;
				end
			end
		end
	end

	// Output size: zero acts as one, large values saturate; limit is size minus one
	assign os_ext   = {4'b0, out_size_q};
	assign os_clamp = (os_ext == 17'd0) ? 17'd1 :
	                  (os_ext > 17'(MAX_OUT_SIZE)) ? 17'(MAX_OUT_SIZE) : os_ext;

	// Derived values are registered; the key match needs at least two items
	// before it reads them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			has_colon_q <= 1'b0;
			tail_ok_q   <= 1'b1;
			limit_q     <= LIM_W'(RST_LIMIT);
		end else begin
			has_colon_q <= has_colon_d;
			tail_ok_q   <= tail_ok_d;
			limit_q     <= LIM_W'(os_clamp - 17'd1);
		end
	end

	assign limit = limit_q;

endmodule

@@ rtl/core/jkse_core.sv @@
// Input register, parser state machine and result register of the extractor.
// Depends on jkse_pkg; key and limit values come from jkse_cfg.
module jkse_core #(
	parameter int MAX_KEY_CHARS = jkse_pkg::MAX_KEY_CHARS_DEF,
	parameter int MAX_OUT_SIZE  = jkse_pkg::MAX_OUT_SIZE_DEF,
	parameter int EFF_MAX       = (MAX_KEY_CHARS < 31) ? MAX_KEY_CHARS : 31,
	parameter int LEN_W         = $clog2(EFF_MAX + 1),
	parameter int LIM_W         = $clog2(MAX_OUT_SIZE)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,
	input  logic                s_tlast,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tlast,
	output logic [1:0]          m_tuser,
	input  jkse_pkg::key_info_t key,
	input  logic [LEN_W-1:0]    eff_len,
	input  logic [LIM_W-1:0]    limit
);

	localparam int MP_W = $clog2(EFF_MAX + 2);

	// Input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv;

	// Parser state
	jkse_pkg::phase_t phase_q, phase_d;
	logic [MP_W-1:0]  mp_q, mp_d;
	logic [LIM_W-1:0] cnt_q, cnt_d;
	logic [2:0]       usk_q, usk_d;

	// Result register
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_has_q, out_done_q, out_found_q;

	logic [7:0] exp_b, kbyte, d, vb;
	logic       enter, fail, emit, dn, fd, hb, mp_done;
	logic [LIM_W:0] cnt_inc;

	// An item moves on when the result slot is free or being emptied
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Key byte at match position minus one; bytes past the stored key read as zero
	always_comb begin
		kbyte = 8'h00;
		for (int k = 0; k < jkse_pkg::KEY_BYTES; k++) begin
			if (int'(mp_q) - 1 == k)
				kbyte = key.chars[k];
		end
	end

	assign exp_b   = (mp_q == '0 || int'(mp_q) == int'(eff_len) + 1) ? jkse_pkg::CH_QUOTE : kbyte;
	assign mp_done = (int'(mp_q) + 1 >= int'(eff_len) + 2);
	assign cnt_inc = {1'b0, cnt_q} + 1'b1;

	// Next state and result for the item in the input stage
	always_comb begin
		phase_d = phase_q;
		mp_d    = mp_q;
		cnt_d   = cnt_q;
		usk_d   = usk_q;
		enter   = 1'b0;
		fail    = 1'b0;
		emit    = 1'b0;
		d       = 8'h00;
		vb      = 8'h00;
		hb      = 1'b0;
		dn      = 1'b0;
		fd      = 1'b0;

		case (phase_q)
			jkse_pkg::PH_MATCH: begin
				if (byte_s1 == exp_b) begin
					if (mp_done) begin
						mp_d = '0;
						if (!key.has_colon)
							phase_d = jkse_pkg::PH_COLON;
						else if (key.tail_ok)
							enter = 1'b1;
						else
							fail = 1'b1;
					end else begin
						mp_d = mp_q + 1'b1;
					end
				end else begin
					// a stray quote may open the next candidate
					mp_d = (byte_s1 == jkse_pkg::CH_QUOTE) ? MP_W'(1) : '0;
				end
			end
			jkse_pkg::PH_COLON: begin
				if (byte_s1 == jkse_pkg::CH_COLON)
					phase_d = jkse_pkg::PH_SPACE;
			end
			jkse_pkg::PH_SPACE: begin
				if (!(byte_s1 inside {jkse_pkg::CH_SPACE, jkse_pkg::CH_TAB})) begin
					if (byte_s1 == jkse_pkg::CH_QUOTE)
						enter = 1'b1;
					else
						fail = 1'b1;
				end
			end
			jkse_pkg::PH_VALUE: begin
				if (cnt_q >= limit || byte_s1 == jkse_pkg::CH_QUOTE) begin
					dn      = 1'b1;
					fd      = 1'b1;
					phase_d = jkse_pkg::PH_IDLE;
				end else if (byte_s1 == jkse_pkg::CH_BSLASH && !last_s1) begin
					phase_d = jkse_pkg::PH_ESC;
				end else begin
					emit = 1'b1;
					d    = byte_s1;
				end
			end
			jkse_pkg::PH_ESC: begin
				emit    = 1'b1;
				phase_d = jkse_pkg::PH_VALUE;
				case (byte_s1)
					jkse_pkg::CH_N: d = jkse_pkg::CH_NL;
					jkse_pkg::CH_T: d = jkse_pkg::CH_TAB;
					jkse_pkg::CH_U: begin
						d       = jkse_pkg::CH_QMARK;
						usk_d   = jkse_pkg::USKIP_N;
						phase_d = jkse_pkg::PH_USKIP;
					end
					default: d = byte_s1;
				endcase
			end
			jkse_pkg::PH_USKIP: begin
				if (usk_q != 3'd0)
					usk_d = usk_q - 3'd1;
				if (usk_q <= 3'd1)
					phase_d = jkse_pkg::PH_VALUE;
			end
			default: ;
		endcase

		// Start of the value: its opening quote, or the key's closing quote when the key holds the colon
		if (enter) begin
			phase_d = jkse_pkg::PH_VALUE;
			cnt_d   = '0;
			if (limit == '0) begin
				dn      = 1'b1;
				fd      = 1'b1;
				phase_d = jkse_pkg::PH_IDLE;
			end
		end
		if (fail) begin
			dn      = 1'b1;
			fd      = 1'b0;
			phase_d = jkse_pkg::PH_IDLE;
		end
		// Emitted byte; the byte that fills the buffer also ends extraction
		if (emit) begin
			vb    = d;
			hb    = 1'b1;
			cnt_d = cnt_inc[LIM_W-1:0];
			if (cnt_inc >= {1'b0, limit}) begin
				dn      = 1'b1;
				fd      = 1'b1;
				phase_d = jkse_pkg::PH_IDLE;
			end
		end

		// End of text: report if not yet done, then start over
		if (last_s1) begin
			if (phase_d != jkse_pkg::PH_IDLE) begin
				dn = 1'b1;
				fd = phase_d inside {jkse_pkg::PH_VALUE, jkse_pkg::PH_ESC, jkse_pkg::PH_USKIP};
			end
			phase_d = jkse_pkg::PH_MATCH;
			mp_d    = '0;
			cnt_d   = '0;
			usk_d   = 3'd0;
		end
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= jkse_pkg::PH_MATCH;
			mp_q    <= '0;
			cnt_q   <= '0;
			usk_q   <= 3'd0;
		end else if (adv) begin
			phase_q <= phase_d;
			mp_q    <= mp_d;
			cnt_q   <= cnt_d;
			usk_q   <= usk_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= hb || dn;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q  <= vb;
			out_has_q   <= hb;
			out_done_q  <= dn;
			out_found_q <= fd;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tlast  = out_done_q;
	assign m_tuser  = {out_found_q, out_has_q};

endmodule

@@ rtl/core/json_key_string_extract.sv @@
// Top level of the JSON key string extractor; depends on jkse_pkg, jkse_cfg and jkse_core.
// Path: a text item is taken into the input register, then its result into the result register.
// Throughput: one text item per cycle; a result held by m_tready low stops the input
// once the input register is also full.
// Reset (arst_n, asynchronous, active low): parser back to key matching, registers to defaults.
module json_key_string_extract #(
	parameter int MAX_KEY_CHARS = jkse_pkg::MAX_KEY_CHARS_DEF,
	parameter int MAX_OUT_SIZE  = jkse_pkg::MAX_OUT_SIZE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // text_byte
	input  logic                            s_tlast,   // last
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // value_byte
	output logic                            m_tlast,   // done_res
	output logic [1:0]                      m_tuser,   // has_byte, found
	input  logic                            cfg_we,
	input  logic [jkse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jkse_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int EFF_MAX = (MAX_KEY_CHARS < 31) ? MAX_KEY_CHARS : 31;
	localparam int LEN_W   = $clog2(EFF_MAX + 1);
	localparam int LIM_W   = $clog2(MAX_OUT_SIZE);

	jkse_pkg::key_info_t key;
	logic [LEN_W-1:0]    eff_len;
	logic [LIM_W-1:0]    limit;

	jkse_cfg #(
		.MAX_KEY_CHARS (MAX_KEY_CHARS),
		.MAX_OUT_SIZE  (MAX_OUT_SIZE),
		.EFF_MAX       (EFF_MAX),
		.LEN_W         (LEN_W),
		.LIM_W         (LIM_W)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.key       (key),
		.eff_len   (eff_len),
		.limit     (limit)
	);

	jkse_core #(
		.MAX_KEY_CHARS (MAX_KEY_CHARS),
		.MAX_OUT_SIZE  (MAX_OUT_SIZE),
		.EFF_MAX       (EFF_MAX),
		.LEN_W         (LEN_W),
		.LIM_W         (LIM_W)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.key      (key),
		.eff_len  (eff_len),
		.limit    (limit)
	);

endmodule

@@ rtl/core/jkse_checker.sv @@
// Port-level checks of the JSON key string extractor, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module jkse_port_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [1:0] m_tuser
);

	// No result is offered while in reset
	`CHK_ASSERT_ALWAYS(a_no_out_in_reset, !arst_n |-> !m_tvalid, "result valid during reset")

	// Every result carries a byte, a done mark, or both
	`CHK_ASSERT(a_result_not_empty, m_tvalid |-> (m_tuser[0] || m_tlast), "empty result item")

	// Found is only reported together with done
	`CHK_ASSERT(a_found_with_done, (m_tvalid && m_tuser[1]) |-> m_tlast, "found without done")

	// Without a byte the data field is zero
	`CHK_ASSERT(a_no_byte_zero, (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'h00), "stale data byte")

	// A stalled result holds
	`CHK_ASSERT(a_stall_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)), "result changed while stalled")

endmodule

bind json_key_string_extract jkse_port_checker u_jkse_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

@@ verif/jkse_checker.sv @@
// Checker for the JSON key string extractor: watches the text, result and register ports,
// predicts every result from its own parser model and compares them in order.
// Depends on jkse_pkg for the register indexes, character codes and parser phases.
`timescale 1ns / 1ps

module jkse_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // text_byte
	input  logic                            s_tlast,   // last
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [7:0]                      m_tdata,   // value_byte
	input  logic                            m_tlast,   // done_res
	input  logic [1:0]                      m_tuser,   // has_byte, found
	input  logic                            cfg_we,
	input  logic [jkse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [jkse_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              pending,
	output int                              mismatches,
	output int                              results_seen,
	output int                              done_found,
	output int                              done_missed
);

	import jkse_pkg::*;

	typedef struct packed {
		logic [7:0] value;
		logic       has_byte;
		logic       done;
		logic       found;
	} extract_res_t;

	// Register copies
	logic [63:0]           key_w [3];
	logic [KEY_LEN_W-1:0]  key_len;
	logic [OUT_SIZE_W-1:0] out_sz;

	// Parser state of the prediction
	phase_t      parse_ph;
	int unsigned match_pos;
	int unsigned out_count;
	logic [2:0]  skip_left;

	extract_res_t extract_q [$];
	extract_res_t seen_r;
	extract_res_t due_r;

	function automatic logic [7:0] key_char(input int unsigned i);
		if (i >= KEY_BYTES)
			return 8'h00;
		return key_w[i / 8][(i % 8) * 8 +: 8];
	endfunction

	function automatic int unsigned key_span();
		int unsigned n;
		n = key_len;
		return (n > MAX_KEY_CHARS_DEF) ? MAX_KEY_CHARS_DEF : n;
	endfunction

	// Most value bytes that fit in the output buffer
	function automatic int unsigned byte_limit();
		int unsigned os;
		os = out_sz;
		if (os == 0)
			os = 1;
		if (os > MAX_OUT_SIZE_DEF)
			os = MAX_OUT_SIZE_DEF;
		return os - 1;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	task automatic report(input string why, input extract_res_t w, input extract_res_t g);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t %s: expected byte %02h has %0b done %0b found %0b, got byte %02h has %0b done %0b found %0b",
				$time, why, w.value, w.has_byte, w.done, w.found,
				g.value, g.has_byte, g.done, g.found);
		end
	endtask

	// Advances the parser by one text item and queues the result it causes, if any
	task automatic parse_byte(input logic [7:0] c, input logic lst);
		int unsigned len;
		int unsigned k;
		int unsigned j;
		logic [7:0] want;
		logic [7:0] d;
		logic enter;
		logic fail;
		logic emit;
		logic ok;
		extract_res_t r;
		r = '0;
		enter = 1'b0;
		fail = 1'b0;
		emit = 1'b0;
		d = 8'h00;
		case (parse_ph)
			PH_MATCH: begin
				len = key_span();
				want = (match_pos == 0 || match_pos == len + 1) ? CH_QUOTE : key_char(match_pos - 1);
				if (c == want) begin
					match_pos++;
					if (match_pos >= len + 2) begin
						match_pos = 0;
						k = 0;
						while (k < len && key_char(k) != CH_COLON)
							k++;
						if (k == len) begin
							parse_ph = PH_COLON;
						end else begin
							// colon inside the key: only blanks may follow it in the key
							ok = 1'b1;
							for (j = k + 1; j < len; j++)
								if (!is_blank(key_char(j)))
									ok = 1'b0;
							if (ok)
								enter = 1'b1;
							else
								fail = 1'b1;
						end
					end
				end else begin
					match_pos = (c == CH_QUOTE) ? 1 : 0;
				end
			end
			PH_COLON: begin
				if (c == CH_COLON)
					parse_ph = PH_SPACE;
			end
			PH_SPACE: begin
				if (!is_blank(c)) begin
					if (c == CH_QUOTE)
						enter = 1'b1;
					else
						fail = 1'b1;
				end
			end
			PH_VALUE: begin
				if (out_count >= byte_limit() || c == CH_QUOTE) begin
					r.done = 1'b1;
					r.found = 1'b1;
					parse_ph = PH_IDLE;
				end else if (c == CH_BSLASH && !lst) begin
					parse_ph = PH_ESC;
				end else begin
					emit = 1'b1;
					d = c;
				end
			end
			PH_ESC: begin
				if (c == CH_N)
					d = CH_NL;
				else if (c == CH_T)
					d = CH_TAB;
				else if (c == CH_U)
					d = CH_QMARK;
				else
					d = c;
				if (c == CH_U) begin
					skip_left = USKIP_N;
					parse_ph = PH_USKIP;
				end else begin
					parse_ph = PH_VALUE;
				end
				emit = 1'b1;
			end
			PH_USKIP: begin
				if (skip_left > 0)
					skip_left--;
				if (skip_left == 0)
					parse_ph = PH_VALUE;
			end
			default: ;
		endcase

		if (enter) begin
			parse_ph = PH_VALUE;
			out_count = 0;
			if (byte_limit() == 0) begin
				r.done = 1'b1;
				r.found = 1'b1;
				parse_ph = PH_IDLE;
			end
		end
		if (fail) begin
			r.done = 1'b1;
			r.found = 1'b0;
			parse_ph = PH_IDLE;
		end
		if (emit) begin
			r.value = d;
			r.has_byte = 1'b1;
			out_count++;
			if (out_count >= byte_limit()) begin
				r.done = 1'b1;
				r.found = 1'b1;
				parse_ph = PH_IDLE;
			end
		end
		// end of text: report what is still open, then start over
		if (lst) begin
			if (parse_ph != PH_IDLE) begin
				r.done = 1'b1;
				r.found = (parse_ph == PH_VALUE || parse_ph == PH_ESC || parse_ph == PH_USKIP);
			end
			parse_ph = PH_MATCH;
			match_pos = 0;
			out_count = 0;
			skip_left = '0;
		end
		if (r.has_byte || r.done)
			extract_q.push_back(r);
	endtask

	// Compare results, track register writes, predict from accepted items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_w[0] = '0;
			key_w[1] = '0;
			key_w[2] = '0;
			key_len = KEY_LEN_W'(RST_KEY_LEN);
			out_sz = OUT_SIZE_W'(RST_OUT_SIZE);
			parse_ph = PH_MATCH;
			match_pos = 0;
			out_count = 0;
			skip_left = '0;
			extract_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				seen_r.value = m_tdata;
				seen_r.has_byte = m_tuser[0];
				seen_r.found = m_tuser[1];
				seen_r.done = m_tlast;
				results_seen++;
				if (seen_r.done) begin
					if (seen_r.found)
						done_found++;
					else
						done_missed++;
				end
				if (extract_q.size() == 0) begin
					report("result with nothing expected", '0, seen_r);
				end else begin
					due_r = extract_q.pop_front();
					if (seen_r !== due_r)
						report("result mismatch", due_r, seen_r);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_KEY_LOW:  key_w[0] = cfg_data;
					CFG_KEY_MID:  key_w[1] = cfg_data;
					CFG_KEY_HIGH: key_w[2] = cfg_data;
					CFG_KEY_LEN:  key_len = cfg_data[KEY_LEN_W-1:0];
					CFG_OUT_SIZE: out_sz = cfg_data[OUT_SIZE_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				parse_byte(s_tdata, s_tlast);
		end
		pending = extract_q.size();
	end

endmodule

@@ verif/tb_top.sv @@
// Top of the JSON key string extractor testbench: clock, reset, text and register stimulus,
// receiver stalls and the verdict. Checking is done by jkse_checker.
// Depends on jkse_pkg, jkse_checker and the json_key_string_extract RTL.
`timescale 1ns / 1ps

module tb_top;

	import jkse_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int SETTLE       = 4;
	localparam int HOLD_CYCLES  = 300;

	// Receiver behaviors
	localparam int RX_READY   = 0;
	localparam int RX_RANDOM  = 1;
	localparam int RX_PATTERN = 2;

	// Kinds of key
	localparam int KEY_PLAIN     = 0;
	localparam int KEY_COLON_OK  = 1;
	localparam int KEY_COLON_BAD = 2;

	// Filling of key register bytes past the key
	localparam int FILL_RANDOM = 0;
	localparam int FILL_ZERO   = 1;
	localparam int FILL_ONES   = 2;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [7:0] s_tdata;   // text_byte
	logic s_tlast;         // last
	logic m_tvalid;
	logic m_tready;
	logic [7:0] m_tdata;   // value_byte
	logic m_tlast;         // done_res
	logic [1:0] m_tuser;   // has_byte, found
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int pending;
	int mismatches;
	int results_seen;
	int done_found;
	int done_missed;

	// Stimulus state
	logic [7:0] txt [$];
	logic [7:0] key_c [KEY_BYTES];
	int key_n;
	int val_max = 12;
	int gap_max;
	int burst_left;
	int items_sent;
	int texts_sent;
	int configs_loaded;
	int rx_mode;
	int hold_asks;
	int cycle_count;

	always begin
		#10;
		clk = 1'b1;
		#10;
		clk = 1'b0;
	end

	json_key_string_extract u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	jkse_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tlast      (s_tlast),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tlast      (m_tlast),
		.m_tuser      (m_tuser),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pending      (pending),
		.mismatches   (mismatches),
		.results_seen (results_seen),
		.done_found   (done_found),
		.done_missed  (done_missed)
	);

	// Receiver: long hold-offs on request, otherwise by mode always ready, random stalls or a fixed stall pattern
	int hold_seen;
	int hold_left;
	int rx_tick;
	always @(posedge clk) begin
		rx_tick++;
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_RANDOM:  m_tready <= ($urandom_range(0, 99) < 60);
				RX_PATTERN: m_tready <= ((rx_tick % 11) < 6);
				default:    m_tready <= 1'b1;
			endcase
		end
	end

	// Run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAILURE");
		$finish;
	end

	function automatic logic [7:0] any_byte();
		return 8'($urandom_range(1, 255));
	endfunction

	// Bytes that tend to move the key matcher around
	function automatic logic [7:0] noise_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return CH_QUOTE;
		if (r == 3)
			return key_c[$urandom_range(0, key_n - 1)];
		if (r == 4)
			return CH_COLON;
		if (r == 5)
			return CH_BSLASH;
		return any_byte();
	endfunction

	task automatic put(input logic [7:0] b);
		txt.push_back(b);
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			txt.push_back(s[i]);
	endtask

	// Value body with a mix of plain bytes and escapes
	task automatic add_value(input int vmax);
		int n;
		int i;
		int j;
		logic [7:0] b;
		n = $urandom_range(0, vmax);
		for (i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0: begin
					put(CH_BSLASH);
					put(CH_N);
				end
				1: begin
					put(CH_BSLASH);
					put(CH_T);
				end
				2: begin
					put(CH_BSLASH);
					put(CH_U);
					for (j = 0; j < 4; j++)
						put(any_byte());
				end
				3: begin
					put(CH_BSLASH);
					put(any_byte());
				end
				default: begin
					do b = any_byte(); while (b == CH_QUOTE || b == CH_BSLASH);
					put(b);
				end
			endcase
		end
	endtask

	// Noise, quoted key, filler, colon, blanks, a value or a bad value start, then trailing bytes
	task automatic build_wellformed(input bit bad_value, input int vmax);
		int n;
		int i;
		logic [7:0] b;
		n = $urandom_range(0, 5);
		for (i = 0; i < n; i++)
			put(noise_byte());
		put(CH_QUOTE);
		for (i = 0; i < key_n; i++)
			put(key_c[i]);
		put(CH_QUOTE);
		n = $urandom_range(0, 2);
		for (i = 0; i < n; i++) begin
			do b = any_byte(); while (b == CH_COLON);
			put($urandom_range(0, 1) ? CH_SPACE : b);
		end
		put(CH_COLON);
		n = $urandom_range(0, 3);
		for (i = 0; i < n; i++)
			put($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
		if (bad_value) begin
			do b = any_byte(); while (b == CH_QUOTE || b == CH_SPACE || b == CH_TAB);
			put(b);
		end else begin
			put(CH_QUOTE);
			add_value(vmax);
			if ($urandom_range(0, 9) != 0)
				put(CH_QUOTE);
		end
		n = $urandom_range(0, 3);
		for (i = 0; i < n; i++)
			put(any_byte());
	endtask

	task automatic build_text();
		int r;
		int cut;
		int n;
		int i;
		txt.delete();
		r = $urandom_range(0, 99);
		if (r < 70) begin
			build_wellformed(1'b0, val_max);
		end else if (r < 80) begin
			// text cut short anywhere
			build_wellformed(1'b0, val_max);
			cut = $urandom_range(1, txt.size());
			txt = txt[0:cut-1];
		end else if (r < 88) begin
			build_wellformed(1'b1, val_max);
		end else begin
			n = $urandom_range(1, 12);
			for (i = 0; i < n; i++)
				put(noise_byte());
		end
	endtask

	// One text item, with bursts and gaps on the sender side
	task automatic send_byte(input logic [7:0] b, input logic lst);
		bit ok;
		if (gap_max != 0 && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, gap_max)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= lst;
		do begin
			@(negedge clk);
			ok = s_tready;
			@(posedge clk);
		end while (!ok);
		items_sent++;
	endtask

	task automatic send_text();
		for (int i = 0; i < txt.size(); i++)
			send_byte(txt[i], i == txt.size() - 1);
		texts_sent++;
	endtask

	// Stop sending and let every expected result come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic pick_key(input int n, input int kind);
		int i;
		int pos;
		logic [7:0] b;
		key_n = n;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 1))
				b = 8'($urandom_range(8'h61, 8'h7A));
			else
				do b = any_byte(); while (b == CH_QUOTE || b == CH_COLON);
			key_c[i] = b;
		end
		if (kind == KEY_COLON_OK) begin
			pos = $urandom_range(0, n - 1);
			key_c[pos] = CH_COLON;
			for (i = pos + 1; i < n; i++)
				key_c[i] = $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
		end else if (kind == KEY_COLON_BAD) begin
			pos = $urandom_range(0, n - 2);
			key_c[pos] = CH_COLON;
			key_c[n - 1] = 8'h7A;
		end
	endtask

	// All five registers; the bytes past the key get the chosen filling
	task automatic load_config(input int osz, input int fill);
		logic [63:0] w [3];
		int i;
		for (i = 0; i < 3; i++) begin
			case (fill)
				FILL_ZERO: w[i] = '0;
				FILL_ONES: w[i] = '1;
				default:   w[i] = {$urandom, $urandom};
			endcase
		end
		for (i = 0; i < key_n; i++)
			w[i / 8][(i % 8) * 8 +: 8] = key_c[i];
		write_reg(CFG_KEY_LOW, w[0]);
		write_reg(CFG_KEY_MID, w[1]);
		write_reg(CFG_KEY_HIGH, w[2]);
		write_reg(CFG_KEY_LEN, CFG_DATA_W'(key_n));
		write_reg(CFG_OUT_SIZE, CFG_DATA_W'(osz));
		cfg_we <= 1'b0;
		configs_loaded++;
	endtask

	// One register setting and a stream of texts under it
	task automatic run_phase(input int n, input int osz, input int kind, input int fill,
		input int rxm, input int gaps, input int target, input bit squeeze);
		int start;
		int t;
		pick_key(n, kind);
		wait_drained();
		load_config(osz, fill);
		rx_mode <= rxm;
		gap_max = gaps;
		start = items_sent;
		t = 0;
		while (items_sent - start < target) begin
			if (t > 0 && $urandom_range(0, 7) == 0)
				wait_drained();
			if (squeeze && t < 2) begin
				// receiver holds off while a long value keeps coming
				hold_asks <= hold_asks + 1;
				txt.delete();
				build_wellformed(1'b0, 40);
			end else begin
				build_text();
			end
			send_text();
			t++;
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		s_tlast <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		rx_mode <= RX_READY;
		hold_asks <= 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: escapes, byte extremes, backslash on the last byte, a failed value
		// start with bytes ignored after it, and a text that ends before any value
		key_n = 1;
		key_c[0] = "k";
		load_config(64, FILL_RANDOM);
		rx_mode <= RX_RANDOM;
		gap_max = 3;
		txt.delete();
		add_str("\"k\": \"\\n\\t\\u00e9");
		put(8'h01);
		put(8'hFF);
		add_str("\\q\\");
		send_text();
		txt.delete();
		add_str("\"k\"x:1}");
		send_text();
		txt.delete();
		add_str("\"x\"");
		send_text();

		// Random texts over several register settings
		run_phase(1, 64, KEY_PLAIN, FILL_ZERO, RX_READY, 0, 80, 1'b0);
		run_phase(24, 4096, KEY_PLAIN, FILL_RANDOM, RX_RANDOM, 6, 120, 1'b1);
		run_phase($urandom_range(1, 24), 1, KEY_PLAIN, FILL_ONES, RX_PATTERN, 4, 70, 1'b0);
		run_phase($urandom_range(1, 24), 2, KEY_PLAIN, FILL_RANDOM, RX_RANDOM, 8, 70, 1'b0);
		run_phase($urandom_range(1, 6), $urandom_range(3, 12), KEY_PLAIN, FILL_RANDOM,
			RX_PATTERN, 3, 75, 1'b0);
		run_phase($urandom_range(1, 8), $urandom_range(13, 80), KEY_COLON_OK, FILL_RANDOM,
			RX_RANDOM, 5, 70, 1'b0);
		run_phase($urandom_range(2, 8), 64, KEY_COLON_BAD, FILL_RANDOM, RX_READY, 2, 50, 1'b0);
		run_phase($urandom_range(1, 24), $urandom_range(13, 4096), KEY_PLAIN, FILL_RANDOM,
			RX_RANDOM, 10, 75, 1'b0);

		wait_drained();
		$display("Run covered %0d text bytes in %0d texts under %0d register settings",
			items_sent, texts_sent, configs_loaded);
		$display("%0d results checked: %0d extractions found, %0d with key or value missing",
			results_seen, done_found, done_missed);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/jkse_pkg.sv
rtl/core/jkse_cfg.sv
rtl/core/jkse_core.sv
rtl/core/json_key_string_extract.sv
rtl/core/jkse_checker.sv
verif/jkse_checker.sv
verif/tb_top.sv
